// ===== hdl/ts_pid_filter_defines.svh =====
// assertion macros shared by the transport stream filter modules
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef TS_PID_FILTER_DEFINES_SVH
`define TS_PID_FILTER_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define TSPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tspf_pkg.sv =====
// constants, register indexes and shared types of the transport stream filter
// no dependencies
package tspf_pkg;

  localparam int unsigned POS_W = 8;
  localparam int unsigned PID_W = 13;
  localparam int unsigned CC_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [7:0] SYNC_BYTE        = 8'h47;
  localparam logic [POS_W-1:0] TS_LEN     = 8'd188;
  localparam logic [POS_W-1:0] PFX_PKT_LEN = 8'd192;

  // header byte positions counted from the sync byte
  localparam logic [POS_W-1:0] POS_SYNC    = 8'd0;
  localparam logic [POS_W-1:0] POS_PID_HI  = 8'd1;
  localparam logic [POS_W-1:0] POS_PID_LO  = 8'd2;
  localparam logic [POS_W-1:0] POS_CTRL    = 8'd3;
  localparam logic [POS_W-1:0] POS_AF_LEN  = 8'd4;
  localparam logic [POS_W-1:0] PLAIN_PAYLOAD_OFS = 8'd4;
  localparam logic [8:0]       AF_BASE_OFS = 9'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_PID     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_PID     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIXED_MODE = 3'd4;

  typedef struct packed {
    logic [PID_W-1:0] video_pid;
    logic             video_enable;
    logic [PID_W-1:0] audio_pid;
    logic             audio_enable;
    logic             prefixed_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_audio;
    logic       unit_start;
    logic       last_in_packet;
  } result_t;

endpackage

// ===== hdl/tspf_if.sv =====
// valid/ready channel interfaces: raw stream bytes, filtered payload, register writes
// uses tspf_pkg for widths
interface tspf_stream_if import tspf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface tspf_result_if import tspf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       is_audio;
  logic       unit_start;
  logic       last_in_packet;
  modport source (output valid, output payload_byte, output is_audio, output unit_start,
                  output last_in_packet, input ready);
  modport sink (input valid, input payload_byte, input is_audio, input unit_start,
                input last_in_packet, output ready);
endinterface

interface tspf_cfg_if import tspf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/tspf_cfg_regs.sv =====
// configuration register file of the transport stream filter
// uses tspf_pkg and the tspf_cfg_if interface
module tspf_cfg_regs import tspf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tspf_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.video_pid     <= '1;
      regs_q.video_enable  <= 1'b0;
      regs_q.audio_pid     <= '1;
      regs_q.audio_enable  <= 1'b0;
      regs_q.prefixed_mode <= 1'b0;
    end else if (cfg_i.valid) begin
      // indexes past the register list are dropped
      case (cfg_i.index)
        CFG_VIDEO_PID:     regs_q.video_pid     <= cfg_i.data[PID_W-1:0];
        CFG_VIDEO_ENABLE:  regs_q.video_enable  <= cfg_i.data[0];
        CFG_AUDIO_PID:     regs_q.audio_pid     <= cfg_i.data[PID_W-1:0];
        CFG_AUDIO_ENABLE:  regs_q.audio_enable  <= cfg_i.data[0];
        CFG_PREFIXED_MODE: regs_q.prefixed_mode <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/tspf_parser.sv =====
// packet tracker: sync lock, header decode, pid match, continuity check, payload select
// uses tspf_pkg, tspf_stream_if and the assertion macros
`include "ts_pid_filter_defines.svh"

module tspf_parser import tspf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  tspf_stream_if.sink  stream_i,
  input  logic         space_i,
  output logic         push_o,
  output result_t      result_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             locked_q, locked_d;
  logic [PID_W-1:0] pid_q, pid_d;
  logic             err_q, err_d;
  logic             start_q, start_d;
  logic             pending_q, pending_d;
  logic             match_q, match_d;
  logic [POS_W-1:0] offset_q, offset_d;
  logic             acc_q, acc_d;
  logic             audio_q, audio_d;
  logic [CC_W-1:0]  last_cc_q, last_cc_d;
  logic [CC_W-1:0]  cc_q, cc_d;

  logic             accept;
  logic [7:0]       b;
  logic [POS_W-1:0] plen;
  logic [POS_W-1:0] pos;
  logic [POS_W:0]   pos_inc;
  logic [8:0]       af_ofs;
  logic             dec_en;
  logic [CC_W-1:0]  dec_cc;
  logic [CC_W-1:0]  cc_expect;
  logic             has_result;

  assign stream_i.ready = space_i;
  assign accept         = stream_i.valid && space_i;
  assign b              = stream_i.stream_byte;
  assign plen           = cfg_i.prefixed_mode ? PFX_PKT_LEN : TS_LEN;
  // a mode change can leave the position past the packet end
  assign pos            = (pos_q >= plen) ? POS_SYNC : pos_q;
  assign pos_inc        = {1'b0, pos} + {{POS_W{1'b0}}, 1'b1};
  assign af_ofs         = AF_BASE_OFS + {1'b0, b};
  assign cc_expect      = last_cc_q + {{(CC_W-1){1'b0}}, 1'b1};

  always_comb begin
    pos_d      = pos;
    locked_d   = locked_q;
    pid_d      = pid_q;
    err_d      = err_q;
    start_d    = start_q;
    pending_d  = pending_q;
    match_d    = match_q;
    offset_d   = offset_q;
    acc_d      = acc_q;
    audio_d    = audio_q;
    last_cc_d  = last_cc_q;
    cc_d       = cc_q;
    dec_en     = 1'b0;
    dec_cc     = cc_q;
    has_result = 1'b0;

    if (pos == POS_SYNC) begin
      if (b != SYNC_BYTE) begin
        locked_d = 1'b0;
        acc_d    = 1'b0;
        pos_d    = POS_SYNC;
      end else begin
        locked_d  = 1'b1;
        pid_d     = '0;
        err_d     = 1'b0;
        start_d   = 1'b0;
        pending_d = 1'b0;
        match_d   = 1'b0;
        offset_d  = '0;
        acc_d     = 1'b0;
        audio_d   = 1'b0;
        cc_d      = '0;
        pos_d     = POS_PID_HI;
      end
    end else if (!locked_q) begin
      pos_d = POS_SYNC;
    end else begin
      if (pos == POS_PID_HI) begin
        err_d     = b[7];
        start_d   = b[6];
        pending_d = 1'b0;
        match_d   = 1'b0;
        pid_d     = {b[4:0], 8'h00};
      end else if (pos == POS_PID_LO) begin
        pid_d = pid_q | {5'b0, b};
      end else if (pos == POS_CTRL) begin
        acc_d = 1'b0;
        cc_d  = b[3:0];
        // no error, not scrambled, payload present
        if (!err_q && (b[7:6] == 2'b00) && b[4]) begin
          if (cfg_i.video_enable && (pid_q == cfg_i.video_pid)) begin
            match_d = 1'b1;
            audio_d = 1'b0;
          end else if (cfg_i.audio_enable && (pid_q == cfg_i.audio_pid)) begin
            match_d = 1'b1;
            audio_d = 1'b1;
          end
          if (match_d) begin
            if (!b[5]) begin
              offset_d = PLAIN_PAYLOAD_OFS;
              dec_en   = 1'b1;
              dec_cc   = b[3:0];
            end else begin
              pending_d = 1'b1;
            end
          end
        end
      end else if ((pos == POS_AF_LEN) && pending_q) begin
        pending_d = 1'b0;
        if (af_ofs > {1'b0, TS_LEN}) begin
          acc_d = 1'b0;
        end else begin
          offset_d = af_ofs[POS_W-1:0];
          dec_en   = 1'b1;
        end
      end

      // accept decision; video also checks and resyncs the continuity counter
      if (dec_en) begin
        if (!match_d) begin
          acc_d = 1'b0;
        end else if (audio_d) begin
          acc_d = 1'b1;
        end else begin
          acc_d     = (dec_cc == cc_expect);
          last_cc_d = dec_cc;
        end
      end

      has_result = acc_d && (pos >= POS_AF_LEN) && (pos >= offset_d) && (pos < TS_LEN);
      pos_d      = (pos_inc >= {1'b0, plen}) ? POS_SYNC : pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      locked_q  <= 1'b0;
      pid_q     <= '0;
      err_q     <= 1'b0;
      start_q   <= 1'b0;
      pending_q <= 1'b0;
      match_q   <= 1'b0;
      offset_q  <= '0;
      acc_q     <= 1'b0;
      audio_q   <= 1'b0;
      last_cc_q <= '0;
      cc_q      <= '0;
    end else if (accept) begin
      pos_q     <= pos_d;
      locked_q  <= locked_d;
      pid_q     <= pid_d;
      err_q     <= err_d;
      start_q   <= start_d;
      pending_q <= pending_d;
      match_q   <= match_d;
      offset_q  <= offset_d;
      acc_q     <= acc_d;
      audio_q   <= audio_d;
      last_cc_q <= last_cc_d;
      cc_q      <= cc_d;
    end
  end

  assign push_o                  = accept && has_result;
  assign result_o.payload_byte   = b;
  assign result_o.is_audio       = audio_d;
  assign result_o.unit_start     = start_d;
  assign result_o.last_in_packet = (pos == (TS_LEN - 8'd1));

  `TSPF_ASSERT_NEXT(a_sync_loss, accept && (pos == POS_SYNC) && (b != SYNC_BYTE), !locked_q, "sync byte missing but still locked")
  `TSPF_ASSERT_NOW(a_push_locked, push_o, locked_q && (pos >= offset_d), "payload request while unlocked or inside header")
  `TSPF_ASSERT_NOW(a_hunt_pos, !locked_q, pos_q == POS_SYNC, "position advanced while hunting")
  `TSPF_ASSERT_NOW(a_pos_range, 1'b1, pos_q < PFX_PKT_LEN, "byte position past longest packet")

endmodule

// ===== hdl/tspf_out_buf.sv =====
// two-entry result register with skid stage in front of the output channel
// uses tspf_pkg, tspf_result_if and the assertion macros
`include "ts_pid_filter_defines.svh"

module tspf_out_buf import tspf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  result_t       data_i,
  output logic          space_o,
  tspf_result_if.source result_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    take;

  assign take    = out_valid_q && result_o.ready;
  assign space_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = push_i;
        skid_d       = data_i;
      end else begin
        out_valid_d = push_i;
        out_d       = data_i;
      end
    end else if (push_i) begin
      // output held by the sink, park the new request
      skid_valid_d = 1'b1;
      skid_d       = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.payload_byte   = out_q.payload_byte;
  assign result_o.is_audio       = out_q.is_audio;
  assign result_o.unit_start     = out_q.unit_start;
  assign result_o.last_in_packet = out_q.last_in_packet;

  `TSPF_ASSERT_NOW(a_skid_order, skid_valid_q, out_valid_q, "skid entry without output entry")
  `TSPF_ASSERT_NOW(a_no_overflow, push_i, !skid_valid_q, "request pushed into full buffer")
  `TSPF_ASSERT_NEXT(a_skid_drain, skid_valid_q && take && !push_i, !skid_valid_q && out_valid_q, "skid entry not moved forward")

endmodule

// ===== hdl/ts_pid_filter.sv =====
// top level of the transport stream pid filter
// uses tspf_pkg, the channel interfaces, tspf_cfg_regs, tspf_parser and tspf_out_buf
//
//   port      dir  request                      handshake
//   stream_i  in   stream_byte                  valid / ready
//   result_o  out  payload_byte, is_audio,      valid / ready
//                  unit_start, last_in_packet
//   cfg_i     in   index, data                  valid / ready (ready always high)
//
// one byte per cycle while stream_i.ready is high; each byte is decoded in the
// cycle it is taken and its payload request lands in the output register, or
// in the skid entry while the sink holds the output register, on the next edge.
// stream_i.ready drops in the cycle after a new request is parked in the skid
// entry and rises again once the sink takes a request. reset clears lock,
// header state, enables and buffer, sets pids to all ones; the filter hunts.
module ts_pid_filter import tspf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  tspf_stream_if.sink   stream_i,
  tspf_result_if.source result_o,
  tspf_cfg_if.sink      cfg_i
);

  cfg_t    cfg;
  logic    push;
  logic    space;
  result_t result;

  tspf_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tspf_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .stream_i (stream_i),
    .space_i  (space),
    .push_o   (push),
    .result_o (result)
  );

  tspf_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (result),
    .space_o  (space),
    .result_o (result_o)
  );

endmodule
